// ===== rtl/bcdl_pkg.sv =====
// Package for the button click / double-click / long-press classifier.
// Holds event and phase codes, register indexes and the state/result structs.
// No dependencies.
package bcdl_pkg;

  // Event codes carried in event_res
  localparam logic [1:0] EV_IDLE   = 2'd0;
  localparam logic [1:0] EV_CLICK  = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  // Lower machine phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_CONFIRM = 2'd1;
  localparam logic [1:0] PH_HOLD    = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  // Input action codes
  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP = 1'd1;

  localparam int CFG_DATA_W = 8;
  localparam logic [7:0] LONG_PRESS_RST = 8'd15;
  localparam logic [7:0] DOUBLE_GAP_RST = 8'd3;
  localparam logic [7:0] TICK_MAX       = 8'd255;

  // Classifier state
  typedef struct packed {
    logic [1:0] phase;
    logic       pending;
    logic [7:0] hold;
    logic [7:0] gap;
  } bcdl_state_t;

  // One result word
  typedef struct packed {
    logic [1:0] event_res;
    logic       clear_shut;
  } bcdl_res_t;

endpackage

// ===== rtl/bcdl_if.sv =====
// Valid/ready channel interfaces for the classifier: scan/tick input and result.
// Depends on nothing.
interface bcdl_in_if;
  logic valid;
  logic ready;
  logic action;
  logic pressed;

  modport source (output valid, output action, output pressed, input ready);
  modport sink   (input valid, input action, input pressed, output ready);
endinterface

interface bcdl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       clear_shut;

  modport source (output valid, output event_res, output clear_shut, input ready);
  modport sink   (input valid, input event_res, input clear_shut, output ready);
endinterface

// ===== rtl/bcdl_core.sv =====
// Next-state and result logic of the classifier for one scan or tick word.
// Purely combinational; depends on bcdl_pkg.
module bcdl_core
  import bcdl_pkg::*;
(
  input  bcdl_state_t st,
  input  logic        action,
  input  logic        pressed,
  input  logic [7:0]  long_press_ticks,
  input  logic [7:0]  double_gap_ticks,
  output bcdl_state_t st_next,
  output bcdl_res_t   res
);

  logic [1:0] low;

  always_comb begin
    st_next        = st;
    low            = EV_IDLE;
    res.event_res  = EV_IDLE;
    res.clear_shut = 1'b0;

    if (action == ACT_TICK) begin
      // tick: saturating counters only
      if (st.hold != TICK_MAX) st_next.hold = st.hold + 8'd1;
      if (st.gap  != TICK_MAX) st_next.gap  = st.gap  + 8'd1;
    end else begin
      // lower machine: press debounce, hold timing, release wait
      unique case (st.phase)
        PH_IDLE: begin
          if (pressed) st_next.phase = PH_CONFIRM;
        end
        PH_CONFIRM: begin
          if (pressed) begin
            st_next.hold  = 8'd0;
            st_next.phase = PH_HOLD;
          end else begin
            st_next.phase = PH_IDLE;
          end
        end
        PH_HOLD: begin
          if (!pressed) begin
            low           = EV_CLICK;
            st_next.phase = PH_IDLE;
          end else if (st.hold >= long_press_ticks) begin
            res.clear_shut = 1'b1;
            low            = EV_LONG;
            st_next.phase  = PH_RELEASE;
          end
        end
        default: begin
          if (!pressed) st_next.phase = PH_IDLE;
        end
      endcase

      // upper machine: hold first click, pair into double or time out
      if (!st.pending) begin
        if (low == EV_CLICK) begin
          st_next.gap     = 8'd0;
          st_next.pending = 1'b1;
          res.clear_shut  = 1'b1;
        end else begin
          res.event_res = low;
        end
      end else begin
        if (low == EV_CLICK) begin
          res.event_res   = EV_DOUBLE;
          st_next.pending = 1'b0;
        end else if (st.gap > double_gap_ticks) begin
          res.event_res   = EV_CLICK;
          st_next.pending = 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/button_click_double_long_classifier.sv =====
// Top level of the push-button click / double-click / long-press classifier.
// Depends on bcdl_pkg, bcdl_in_if, bcdl_out_if and bcdl_core.
//
//   channel   dir  payload                      notes
//   item      in   action[0], pressed[0]        0 = scan, 1 = tick
//   result    out  event_res[1:0], clear_shut   one word per item
//   cfg_*     in   cfg_index[0], cfg_data[7:0]  write only
//
// One item per cycle: state updates at the accepting edge, and the result
// word sits in an output register the cycle after.
// An item is taken whenever the output register is empty or is being drained.
// Reset (rst, synchronous) clears phase, pending flag and counters and loads
// long_press_ticks = 15 and double_gap_ticks = 3.
module button_click_double_long_classifier
  import bcdl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  bcdl_in_if.sink              item,
  bcdl_out_if.source           result,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bcdl_state_t st;
  bcdl_state_t st_next;
  bcdl_res_t   res_next;
  bcdl_res_t   res;
  logic        res_valid;
  logic [7:0]  long_press_ticks;
  logic [7:0]  double_gap_ticks;
  logic        accept;

  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;

  bcdl_core u_core (
    .st               (st),
    .action           (item.action),
    .pressed          (item.pressed),
    .long_press_ticks (long_press_ticks),
    .double_gap_ticks (double_gap_ticks),
    .st_next          (st_next),
    .res              (res_next)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RST;
      double_gap_ticks <= DOUBLE_GAP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LONG_PRESS: long_press_ticks <= cfg_data;
        default:        double_gap_ticks <= cfg_data;
      endcase
    end
  end

  // classifier state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign result.valid      = res_valid;
  assign result.event_res  = res.event_res;
  assign result.clear_shut = res.clear_shut;

`ifndef ASSERT_OFF
  // a tick word always yields an idle result
  a_tick_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == ACT_TICK) |=>
      (res_valid && res.event_res == EV_IDLE && !res.clear_shut))
    else $error("tick produced a non-idle result");

  // a double click needs a click already pending
  a_double_needs_pending: assert property (@(posedge clk) disable iff (rst)
    (accept && !st.pending) |=> (res.event_res != EV_DOUBLE))
    else $error("double click without a pending click");

  // dropping the pending click always emits an event
  a_pending_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && st.pending) |=> (st.pending || res.event_res != EV_IDLE))
    else $error("pending click lost");

  // a long press moves the lower machine to the release wait
  a_long_to_release: assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == ACT_SCAN && st.phase == PH_HOLD && item.pressed &&
     st.hold >= long_press_ticks) |=> (st.phase == PH_RELEASE && res.clear_shut))
    else $error("long press did not enter release wait");
`endif

endmodule

// ===== sim/button_click_double_long_classifier_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for button_click_double_long_classifier: random scan/tick words,
// an event predictor in a scoreboard class, and both limit registers swept.
// Depends on bcdl_pkg, bcdl_in_if, bcdl_out_if and the classifier RTL.
module button_click_double_long_classifier_tb;
  import bcdl_pkg::*;

  localparam int STALL_LIMIT = 2000;

  // Predicts the event word for each accepted scan/tick and checks result words
  class click_scoreboard;
    logic [1:0] phase;
    logic       click_held;
    logic [7:0] hold_cnt;
    logic [7:0] gap_cnt;
    logic [7:0] long_lim;
    logic [7:0] gap_lim;
    bcdl_res_t  words_due[$];
    int         errors;
    int         words_seen;
    int         event_hits[4];

    function new();
      phase      = PH_IDLE;
      click_held = 1'b0;
      hold_cnt   = 8'd0;
      gap_cnt    = 8'd0;
      long_lim   = LONG_PRESS_RST;
      gap_lim    = DOUBLE_GAP_RST;
      errors     = 0;
      words_seen = 0;
      foreach (event_hits[i]) event_hits[i] = 0;
    endfunction

    function void set_limits(logic [7:0] lp, logic [7:0] dg);
      long_lim = lp;
      gap_lim  = dg;
    endfunction

    // Lower machine on the level, then the click-pairing machine on its event
    function void classify_word(logic act, logic prs);
      logic [1:0] lower;
      logic [1:0] ev;
      logic       clr;
      bcdl_res_t  w;
      lower = EV_IDLE;
      ev    = EV_IDLE;
      clr   = 1'b0;
      if (act == ACT_TICK) begin
        if (hold_cnt != TICK_MAX) hold_cnt = hold_cnt + 8'd1;
        if (gap_cnt != TICK_MAX) gap_cnt = gap_cnt + 8'd1;
      end else begin
        case (phase)
          PH_IDLE: begin
            if (prs) phase = PH_CONFIRM;
          end
          PH_CONFIRM: begin
            if (prs) begin
              hold_cnt = 8'd0;
              phase    = PH_HOLD;
            end else begin
              phase = PH_IDLE;
            end
          end
          PH_HOLD: begin
            if (!prs) begin
              lower = EV_CLICK;
              phase = PH_IDLE;
            end else if (hold_cnt >= long_lim) begin
              clr   = 1'b1;
              lower = EV_LONG;
              phase = PH_RELEASE;
            end
          end
          default: begin
            if (!prs) phase = PH_IDLE;
          end
        endcase
        if (!click_held) begin
          if (lower == EV_CLICK) begin
            gap_cnt    = 8'd0;
            click_held = 1'b1;
            clr        = 1'b1;
          end else begin
            ev = lower;
          end
        end else if (lower == EV_CLICK) begin
          ev         = EV_DOUBLE;
          click_held = 1'b0;
        end else if (gap_cnt > gap_lim) begin
          // long press is dropped here; the held click goes out
          ev         = EV_CLICK;
          click_held = 1'b0;
        end
      end
      w.event_res  = ev;
      w.clear_shut = clr;
      words_due.push_back(w);
    endfunction

    function void check_word(logic [1:0] ev, logic clr);
      bcdl_res_t w;
      if (words_due.size() == 0) begin
        $error("result word with nothing due: event_res=%0d clear_shut=%0d", ev, clr);
        errors++;
        return;
      end
      w = words_due.pop_front();
      words_seen++;
      event_hits[w.event_res]++;
      if (ev !== w.event_res) begin
        $error("event_res: expected %0d, got %0d", w.event_res, ev);
        errors++;
      end
      if (clr !== w.clear_shut) begin
        $error("clear_shut: expected %0d, got %0d", w.clear_shut, clr);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  steady;
  int                    n_sent;
  int                    n_settings;
  click_scoreboard       sb;

  bcdl_in_if  item_ch ();
  bcdl_out_if result_ch ();

  button_click_double_long_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Result-side backpressure, about one stall in ten
  always @(negedge clk) begin
    result_ch.ready <= rst ? 1'b0 : (steady || $urandom_range(99) >= 10);
  end

  // Monitor: check result words, then feed accepted words to the predictor
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready)
        sb.check_word(result_ch.event_res, result_ch.clear_shut);
      if (item_ch.valid && item_ch.ready)
        sb.classify_word(item_ch.action, item_ch.pressed);
    end
  end

  // Watchdog on cycles with no handshake on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("button_click_double_long_classifier verification failed");
    $finish;
  end

  // One input word; random idle cycles ahead of it unless in a steady stretch
  task automatic send_word(input logic act, input logic prs);
    while (!steady && $urandom_range(99) < 10) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.action  <= act;
    item_ch.pressed <= prs;
    do @(posedge clk); while (!item_ch.ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic scan(input logic prs);
    send_word(ACT_SCAN, prs);
  endtask

  task automatic tick();
    send_word(ACT_TICK, 1'($urandom_range(1)));
  endtask

  // Hold the button through n ticks, then release
  task automatic press_for(input int n, input bit end_held);
    scan(1'b1);
    scan(1'b1);
    repeat (n) begin
      tick();
      if ($urandom_range(3) == 0) scan(1'b1);
    end
    if (end_held) scan(1'b1);
    scan(1'b0);
  endtask

  // Released button through n ticks
  task automatic idle_for(input int n);
    repeat (n) begin
      tick();
      if ($urandom_range(3) == 0) scan(1'b0);
    end
    scan(1'b0);
  endtask

  // Tick count clustered around a limit, or short
  function automatic int pick_span(input int lim);
    int near;
    if ($urandom_range(3) == 0) begin
      near = lim + int'($urandom_range(2)) - 1;
      return (near < 0) ? 0 : near;
    end
    return int'($urandom_range(0, (lim < 6) ? lim + 1 : 6));
  endfunction

  // Stop sending and wait for every due word to come back
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (sb.words_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] lp, input logic [7:0] dg);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_LONG_PRESS;
    cfg_data  <= lp;
    @(negedge clk);
    cfg_index <= REG_DOUBLE_GAP;
    cfg_data  <= dg;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limits(lp, dg);
    n_settings++;
  endtask

  // Mostly press/release gestures with random timing, some raw noise
  task automatic run_gestures(input int budget);
    int start;
    int pick;
    start = n_sent;
    while (n_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        press_for(pick_span(int'(sb.long_lim)), 1'($urandom_range(1)));
        idle_for(pick_span(int'(sb.gap_lim)));
      end else if (pick < 98) begin
        repeat ($urandom_range(1, 8))
          send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    clk                  = 1'b0;
    rst                  = 1'b1;
    steady               = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_index            = REG_LONG_PRESS;
    cfg_data             = '0;
    item_ch.valid        = 1'b0;
    item_ch.action       = ACT_SCAN;
    item_ch.pressed      = 1'b0;
    result_ch.ready      = 1'b0;
    n_sent               = 0;
    n_settings           = 0;
    sb                   = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: short limits so every event shows up quickly
    apply_settings(8'd2, 8'd1);
    tick();
    scan(1'b0);
    scan(1'b1); scan(1'b0);                          // bounce back to idle
    scan(1'b1); scan(1'b1); scan(1'b0);              // first click held
    tick(); tick(); scan(1'b0);                      // gap exceeded, single click
    scan(1'b1); scan(1'b1); scan(1'b0);
    scan(1'b1); scan(1'b1); scan(1'b0);              // double click
    scan(1'b1); scan(1'b1); tick(); tick();
    scan(1'b1); scan(1'b1); scan(1'b0);              // long press, wait release
    scan(1'b1); scan(1'b1); scan(1'b0);
    scan(1'b1); scan(1'b1); tick(); tick(); tick();
    scan(1'b1); scan(1'b0);                          // long dropped, held click out

    apply_settings(LONG_PRESS_RST, DOUBLE_GAP_RST);
    run_gestures(30);
    apply_settings(8'd0, 8'd0);
    run_gestures(30);

    // Counters pinned at full scale
    apply_settings(8'd255, 8'd255);
    press_for(260, 1'b1);
    idle_for(260);
    run_gestures(10);

    steady = 1'b1;
    apply_settings(8'($urandom_range(1, 20)), 8'($urandom_range(0, 10)));
    run_gestures(80);
    steady = 1'b0;
    apply_settings(8'($urandom_range(1, 20)), 8'($urandom_range(0, 10)));
    run_gestures(30);

    drain_results();
    repeat (4) @(negedge clk);
    $display("Covered %0d scan/tick words over %0d limit settings (0 and 255 included).",
             n_sent, n_settings);
    $display("Results: %0d idle, %0d click, %0d double click, %0d long press.",
             sb.event_hits[EV_IDLE], sb.event_hits[EV_CLICK],
             sb.event_hits[EV_DOUBLE], sb.event_hits[EV_LONG]);
    if (sb.errors == 0)
      $display("button_click_double_long_classifier verification clean");
    else
      $display("button_click_double_long_classifier verification failed");
    $finish;
  end

endmodule
